/* rtl/scd_pkg.sv */
// ----------------------------------------------------------------------------
// Serial I/O command decoder package
// Payload types, character codes and the decimal conversion shared by the
// decoder, the reply serializer and the channel interfaces.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int FRAME_LEN = 7;
  localparam int PINS_W    = 12;
  localparam int IDX_W     = 4;

  localparam logic [2:0] FRAME_LAST = 3'(FRAME_LEN - 1);

  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_QM = 8'h3F;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] CH_O  = 8'h4F;
  localparam logic [7:0] CH_P  = 8'h50;
  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_B  = 8'h42;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_F  = 8'h46;
  localparam logic [7:0] CH_K  = 8'h4B;
  localparam logic [7:0] CH_H  = 8'h48;
  localparam logic [7:0] CH_L  = 8'h4C;

  localparam logic [23:0] PAY_INV = 24'h494E56;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
    logic [2:0] sensor_channel;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        reply_byte;
    logic              last_byte;
    logic [PINS_W-1:0] output_pins;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic              sensor;
    logic              stored;
    logic [23:0]       pay;
    logic [PINS_W-1:0] pins;
  } cmd_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [23:0] dec3(input logic [7:0] v);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [14:0] prod;
    logic [3:0]  t;
    logic [7:0]  u;
    h    = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r    = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
    prod = 15'(r) * 15'd205;
    t    = prod[14:11];
    u    = r - 8'(t) * 8'd10;
    return {CH_0 + 8'(h), CH_0 + 8'(t), CH_0 + u};
  endfunction

endpackage

/* rtl/scd_in_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one serial byte or sensor update.
// ----------------------------------------------------------------------------
interface scd_in_if;
  logic              valid;
  logic              ready;
  scd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/scd_out_if.sv */
// ----------------------------------------------------------------------------
// Reply channel
// Valid/ready channel that carries one byte of a reply frame.
// ----------------------------------------------------------------------------
interface scd_out_if;
  logic               valid;
  logic               ready;
  scd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/serial_io_command_decoder.sv */
// ----------------------------------------------------------------------------
// Serial I/O command decoder
// Decodes <?abc?> command frames from a serial byte stream, keeps sensor
// samples and output switch states, and sends seven-byte reply frames.
//
//   Port      Role    Payload
//   request   sink    kind, byte_value, sensor_channel
//   reply     source  reply_byte, last_byte, output_pins
//
// One request is taken every cycle unless stalled; a framed command and its
// sensor memory read are registered, then its seven reply bytes follow.
// Requests keep streaming while a reply is sent; they stall only when a
// second framed command waits behind a reply still in progress.
// Synchronous reset clears the frame window, the switches and the sensor
// valid bits, so unwritten samples read as zero.
// ----------------------------------------------------------------------------
module serial_io_command_decoder #(
  parameter int SENSOR_COUNT = 8,
  parameter int OUTPUT_COUNT = 12
) (
  input logic       clk,
  input logic       rst,
  scd_in_if.sink    request,
  scd_out_if.source reply
);
  import scd_pkg::*;

  localparam int RAM_AW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  cmd_t       cmd;
  ram_req_t   ram_req;
  logic       advance;
  logic [7:0] rdata;

  scd_decode #(
    .SENSOR_COUNT(SENSOR_COUNT),
    .OUTPUT_COUNT(OUTPUT_COUNT)
  ) u_decode (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .advance (advance),
    .cmd     (cmd),
    .ram_req (ram_req)
  );

  scd_ram #(
    .WIDTH(8),
    .DEPTH(SENSOR_COUNT),
    .AW   (RAM_AW)
  ) u_sensor_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr[RAM_AW-1:0]),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr[RAM_AW-1:0]),
    .rdata (rdata)
  );

  scd_reply u_reply (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rdata   (rdata),
    .advance (advance),
    .reply   (reply)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !request.ready |-> cmd.valid && reply.valid)
    else $error("request stalled with no reply pending");

endmodule

/* rtl/scd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/scd_decode.sv */
// ----------------------------------------------------------------------------
// Frame decoder
// Shifts serial bytes through the frame window, decodes framed commands,
// updates the output switches and issues sensor memory accesses.
// ----------------------------------------------------------------------------
module scd_decode #(
  parameter int SENSOR_COUNT = 8,
  parameter int OUTPUT_COUNT = 12
) (
  input  logic              clk,
  input  logic              rst,
  scd_in_if.sink            request,
  input  logic              advance,
  output scd_pkg::cmd_t     cmd,
  output scd_pkg::ram_req_t ram_req
);
  import scd_pkg::*;

  logic [7:0]              hist [FRAME_LEN-1];
  logic [SENSOR_COUNT-1:0] stored;
  logic [OUTPUT_COUNT-1:0] bits;
  logic [OUTPUT_COUNT-1:0] bits_next;
  logic [OUTPUT_COUNT-1:0] out_sel;
  logic [SENSOR_COUNT-1:0] sen_sel;
  logic [SENSOR_COUNT-1:0] wr_sel;
  cmd_t                    cmd_next;
  logic                    accept;
  logic                    serial;
  logic                    framed;
  logic [7:0]              val;
  logic [7:0]              ca;
  logic [7:0]              cb;
  logic [7:0]              cc;
  logic                    is_dig;
  logic [IDX_W-1:0]        dnum;
  logic [IDX_W-1:0]        onum;
  logic                    sensor_ok;
  logic                    out_ok;
  logic                    chan_ok;

  assign request.ready = !cmd.valid || advance;
  assign accept = request.valid && request.ready;
  assign serial = !request.data.kind;
  assign val    = request.data.byte_value;
  assign framed = (hist[0] == CH_LT) && (hist[1] == CH_QM) &&
                  (hist[FRAME_LEN-2] == CH_QM) && (val == CH_GT);
  assign ca = hist[2];
  assign cb = hist[3];
  assign cc = hist[4];

  assign is_dig    = (cc >= CH_0) && (cc <= CH_9);
  assign dnum      = IDX_W'(cc - CH_0);
  assign onum      = is_dig ? dnum : ((cc == CH_A) ? IDX_W'(10) : IDX_W'(11));
  assign sensor_ok = is_dig && ({1'b0, dnum} < 5'(SENSOR_COUNT));
  assign out_ok    = (is_dig || (cc == CH_A) || (cc == CH_B)) &&
                     ({1'b0, onum} < 5'(OUTPUT_COUNT));
  assign chan_ok   = {2'b00, request.data.sensor_channel} < 5'(SENSOR_COUNT);

  always_comb begin
    for (int i = 0; i < OUTPUT_COUNT; i++) begin
      out_sel[i] = (onum == IDX_W'(i));
    end
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      sen_sel[i] = (dnum == IDX_W'(i));
      wr_sel[i]  = ({1'b0, request.data.sensor_channel} == IDX_W'(i));
    end
  end

  always_comb begin
    bits_next       = bits;
    cmd_next.valid  = serial && framed;
    cmd_next.sensor = 1'b0;
    cmd_next.stored = 1'b0;
    cmd_next.pay    = PAY_INV;
    if ((ca == CH_S) && (cb == CH_E)) begin
      if (sensor_ok) begin
        cmd_next.sensor = 1'b1;
        cmd_next.stored = |(stored & sen_sel);
      end
    end else if (((ca == CH_S) || (ca == CH_C) || (ca == CH_P)) && (cb == CH_O)) begin
      if (out_ok) begin
        if (ca == CH_S) begin
          bits_next    = bits | out_sel;
          cmd_next.pay = {CH_O, CH_O, CH_K};
        end else if (ca == CH_C) begin
          bits_next    = bits & ~out_sel;
          cmd_next.pay = {CH_O, CH_O, CH_K};
        end else begin
          cmd_next.pay = {CH_O, CH_O, (|(bits & out_sel)) ? CH_N : CH_F};
        end
      end
    end else if ((ca == CH_S) && (cb == CH_H) && (cc == CH_L)) begin
      cmd_next.pay = {CH_E, CH_H, CH_L};
    end
    cmd_next.pins = PINS_W'(bits_next);
  end

  assign ram_req.we    = accept && !serial && chan_ok;
  assign ram_req.waddr = {1'b0, request.data.sensor_channel};
  assign ram_req.wdata = val;
  assign ram_req.re    = accept;
  assign ram_req.raddr = dnum;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
        hist[i] <= 8'h00;
      end
      stored    <= '0;
      bits      <= '0;
      cmd.valid <= 1'b0;
    end else begin
      if (accept) begin
        cmd <= cmd_next;
        if (serial) begin
          for (int i = 0; i < FRAME_LEN - 2; i++) begin
            hist[i] <= hist[i+1];
          end
          hist[FRAME_LEN-2] <= val;
          if (framed) begin
            bits <= bits_next;
          end
        end else if (chan_ok) begin
          stored <= stored | wr_sel;
        end
      end else if (advance) begin
        cmd.valid <= 1'b0;
      end
    end
  end

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && !advance |=> cmd.valid && $stable(cmd.pay) && $stable(cmd.pins))
    else $error("pending command changed while stalled");

  a_only_framed: assert property (@(posedge clk) disable iff (rst)
    accept && !(serial && framed) |=> !cmd.valid)
    else $error("command raised without a complete frame");

  a_pins_steady: assert property (@(posedge clk) disable iff (rst)
    !(accept && serial && framed) |=> $stable(bits))
    else $error("output switches changed outside a framed command");

endmodule

/* rtl/scd_reply.sv */
// ----------------------------------------------------------------------------
// Reply serializer
// Takes a decoded command with its sensor read data, forms the payload and
// sends the seven-byte reply frame one byte per handshake.
// ----------------------------------------------------------------------------
module scd_reply (
  input  logic          clk,
  input  logic          rst,
  input  scd_pkg::cmd_t cmd,
  input  logic [7:0]    rdata,
  output logic          advance,
  scd_out_if.source     reply
);
  import scd_pkg::*;

  logic              busy;
  logic [2:0]        cnt;
  logic [23:0]       pay;
  logic [PINS_W-1:0] pins;
  logic              send;
  logic              done;
  logic              load;
  logic [7:0]        byte_sel;

  assign send    = busy && reply.ready;
  assign done    = send && (cnt == FRAME_LAST);
  assign advance = !busy || done;
  assign load    = cmd.valid && advance;

  always_comb begin
    case (cnt)
      3'd0:    byte_sel = CH_LT;
      3'd1:    byte_sel = CH_QM;
      3'd2:    byte_sel = pay[23:16];
      3'd3:    byte_sel = pay[15:8];
      3'd4:    byte_sel = pay[7:0];
      3'd5:    byte_sel = CH_QM;
      default: byte_sel = CH_GT;
    endcase
  end

  assign reply.valid            = busy;
  assign reply.data.reply_byte  = byte_sel;
  assign reply.data.last_byte   = (cnt == FRAME_LAST);
  assign reply.data.output_pins = pins;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
        pins <= cmd.pins;
        if (cmd.sensor) begin
          pay <= dec3(cmd.stored ? rdata : 8'h00);
        end else begin
          pay <= cmd.pay;
        end
      end else if (done) begin
        busy <= 1'b0;
        cnt  <= 3'd0;
      end else if (send) begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  a_keep_frame: assert property (@(posedge clk) disable iff (rst)
    send && (cnt != FRAME_LAST) |=> busy && (cnt == $past(cnt) + 3'd1))
    else $error("reply frame cut short");

  a_release: assert property (@(posedge clk) disable iff (rst)
    done && !cmd.valid |=> !busy)
    else $error("serializer stayed busy after the last byte");

  a_fresh_frame: assert property (@(posedge clk) disable iff (rst)
    load |=> busy && (cnt == 3'd0))
    else $error("new reply does not start at the first byte");

endmodule
